[hw/rtl/svie_pkg.sv]
// Package for the stack machine instruction execute block.
// Holds the item and result types, opcode and address-kind codes and sizes.
// Used by the front end, the back end and the top level; depends on nothing.
package svie_pkg;

    localparam int RAM_ADDR_BITS = 16;
    localparam int RAM_DEPTH     = 1 << RAM_ADDR_BITS;
    localparam int FQ_AW         = 2;
    localparam int FQ_DEPTH      = 1 << FQ_AW;

    typedef enum logic [4:0] {
        OP_HLT   = 5'd0,
        OP_MOVCA = 5'd1,
        OP_MOVCR = 5'd2,
        OP_MOVAR = 5'd3,
        OP_MOVRR = 5'd4,
        OP_ADDAC = 5'd5,
        OP_ADDAA = 5'd6,
        OP_ADDRC = 5'd7,
        OP_EQAA  = 5'd8,
        OP_PEEK  = 5'd9,
        OP_IF    = 5'd10,
        OP_JMP   = 5'd11,
        OP_JMPIN = 5'd12,
        OP_RET   = 5'd13,
        OP_LEAVE = 5'd14,
        OP_CALL  = 5'd15,
        OP_PUSHA = 5'd16,
        OP_PUSHR = 5'd17,
        OP_POPA  = 5'd18,
        OP_POPR  = 5'd19,
        OP_PUSHB = 5'd20,
        OP_POPB  = 5'd21,
        OP_SYS   = 5'd22
    } t_op;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_REG = 2'd1;
    localparam logic [1:0] ST_BAD_OP  = 2'd2;

    localparam logic [7:0] REG_R0 = 8'd0;
    localparam logic [7:0] REG_SP = 8'd3;
    localparam logic [7:0] REG_BP = 8'd4;

    localparam logic [15:0] SYS_PUTC = 16'd0;
    localparam logic [15:0] SYS_GETC = 16'd1;
    localparam logic [15:0] SYS_EXT  = 16'd2;

    // Where a RAM word of an instruction lives.
    typedef enum logic [2:0] {
        AK_A    = 3'd0,
        AK_B    = 3'd1,
        AK_SP   = 3'd2,
        AK_SPM1 = 3'd3,
        AK_SPM2 = 3'd4,
        AK_BPM2 = 3'd5,
        AK_ZERO = 3'd6
    } t_ak;

    typedef struct packed {
        logic [4:0]  op;
        logic [15:0] a;
        logic [15:0] b;
        logic [7:0]  rf;
        logic [7:0]  rs;
        logic [15:0] ft;
        logic [7:0]  sin;
        logic [1:0]  st;
        logic        rd_x;
        logic        rd_y;
        t_ak         xk;
        t_ak         yk;
        logic [1:0]  wn;
        t_ak         wk;
    } t_item;

    typedef struct packed {
        logic [15:0] next_ip;
        logic        skip_next;
        logic        is_halted;
        logic        char_valid;
        logic [7:0]  char_out;
        logic        ext_valid;
        logic [7:0]  ext_index;
        logic [1:0]  status;
    } t_res;

endpackage

[hw/rtl/svie_ram.sv]
// Generic single-port RAM with registered read data.
// Standalone; no package needed.
module svie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/svie_front.sv]
// Front end: takes instruction beats, checks register indexes and opcode,
// plans the RAM accesses and queues the classified item. Uses svie_pkg.
module svie_front import svie_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_hold,
    input  logic [4:0]  i_opcode,
    input  logic [15:0] i_operand_a,
    input  logic [15:0] i_operand_b,
    input  logic [7:0]  i_reg_first,
    input  logic [7:0]  i_reg_second,
    input  logic [15:0] i_fall_through_ip,
    input  logic [7:0]  i_stdin_byte,
    output logic        o_full,
    output logic        o_valid,
    output t_item       o_item,
    input  logic        i_take
);

    t_item              r_q [FQ_DEPTH];
    logic [FQ_AW-1:0]   r_wp, r_rp;
    logic [FQ_AW:0]     r_cnt;
    t_item              w_c;
    logic               w_rf_ok, w_rs_ok, w_push, w_pop;

    assign w_rf_ok = (i_reg_first <= REG_BP);
    assign w_rs_ok = (i_reg_second <= REG_BP);

    always_comb begin
        w_c      = '0;
        w_c.op   = i_opcode;
        w_c.a    = i_operand_a;
        w_c.b    = i_operand_b;
        w_c.rf   = i_reg_first;
        w_c.rs   = i_reg_second;
        w_c.ft   = i_fall_through_ip;
        w_c.sin  = i_stdin_byte;
        w_c.st   = ST_OK;
        w_c.xk   = AK_A;
        w_c.yk   = AK_B;
        w_c.wk   = AK_A;
        case (i_opcode)
            OP_HLT, OP_JMP: begin
            end
            OP_MOVCA: begin
                w_c.wn = 2'd2; w_c.wk = AK_B;
            end
            OP_MOVCR, OP_ADDRC: begin
                if (!w_rf_ok) w_c.st = ST_BAD_REG;
            end
            OP_MOVAR: begin
                w_c.rd_x = 1'b1;
                if (!w_rf_ok) w_c.st = ST_BAD_REG;
            end
            OP_MOVRR: begin
                if (!(w_rf_ok && w_rs_ok)) w_c.st = ST_BAD_REG;
            end
            OP_ADDAC, OP_IF, OP_JMPIN: begin
                w_c.rd_x = 1'b1;
            end
            OP_ADDAA, OP_EQAA: begin
                w_c.rd_x = 1'b1; w_c.rd_y = 1'b1;
            end
            OP_PEEK: begin
                w_c.rd_x = 1'b1; w_c.wn = 2'd2; w_c.wk = AK_B;
            end
            OP_RET: begin
                w_c.rd_x = 1'b1; w_c.xk = AK_SPM2;
            end
            OP_LEAVE: begin
                w_c.rd_x = 1'b1; w_c.xk = AK_BPM2;
            end
            OP_CALL: begin
                w_c.wn = 2'd2; w_c.wk = AK_SP;
            end
            OP_PUSHA: begin
                w_c.rd_x = 1'b1; w_c.wn = 2'd2; w_c.wk = AK_SP;
            end
            OP_PUSHR: begin
                w_c.wn = 2'd2; w_c.wk = AK_SP;
                if (!w_rf_ok) w_c.st = ST_BAD_REG;
            end
            OP_POPA: begin
                w_c.rd_x = 1'b1; w_c.xk = AK_SPM2; w_c.wn = 2'd2;
            end
            OP_POPR: begin
                w_c.rd_x = 1'b1; w_c.xk = AK_SPM2;
                if (!w_rf_ok) w_c.st = ST_BAD_REG;
            end
            OP_PUSHB: begin
                w_c.rd_x = 1'b1; w_c.wn = 2'd1; w_c.wk = AK_SP;
            end
            OP_POPB: begin
                w_c.rd_y = 1'b1; w_c.yk = AK_SPM1; w_c.wn = 2'd2;
            end
            OP_SYS: begin
                w_c.rd_x = 1'b1; w_c.xk = AK_ZERO;
                w_c.rd_y = 1'b1; w_c.yk = AK_SPM1;
                w_c.wn   = 2'd1; w_c.wk = AK_SP;
            end
            default: begin
                w_c.st = ST_BAD_OP;
            end
        endcase
        // A rejected instruction touches neither RAM nor registers.
        if (w_c.st != ST_OK) begin
            w_c.rd_x = 1'b0;
            w_c.rd_y = 1'b0;
            w_c.wn   = 2'd0;
        end
    end

    assign o_full  = (r_cnt == (FQ_AW+1)'(FQ_DEPTH)) || i_hold;
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_c;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (FQ_AW+1)'(w_push) - (FQ_AW+1)'(w_pop);
        end
    end

endmodule

[hw/rtl/svie_back.sv]
// Back end: owns the machine state and the byte RAM, reads the operand
// bytes one a cycle, executes the item and writes results back.
// Uses svie_pkg and svie_ram.
module svie_back import svie_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_take,
    output logic  o_res_valid,
    output t_res  o_res,
    input  logic  i_res_ready,
    output logic  o_clearing
);

    localparam int AW = RAM_ADDR_BITS;

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_RD   = 6'b000100,
        S_EXEC = 6'b001000,
        S_WR   = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_clr;
    t_item         r_it;
    logic [AW-1:0] r_xa, r_ya, r_wa;
    logic [1:0]    r_slot, r_slot_end, r_cap_slot;
    logic          r_iss, r_cap_v;
    logic [7:0]    r_byte [4];
    logic [1:0]    r_wn;
    logic          r_widx;
    logic [15:0]   r_wdata;
    logic [15:0]   r_gp [3];
    logic [15:0]   r_sp, r_bp;
    logic          r_halt;
    t_res          r_res;

    logic          w_we;
    logic [AW-1:0] w_addr, w_slot_addr;
    logic [7:0]    w_wdata, w_rdata;
    logic          w_rd_any;

    function automatic logic [15:0] f_addr(t_ak k, logic [15:0] a, logic [15:0] b,
                                           logic [15:0] sp, logic [15:0] bp);
        logic [15:0] v;
        case (k)
            AK_A:    v = a;
            AK_B:    v = b;
            AK_SP:   v = sp;
            AK_SPM1: v = sp - 16'd1;
            AK_SPM2: v = sp - 16'd2;
            AK_BPM2: v = bp - 16'd2;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    svie_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    always_comb begin
        case (r_slot)
            2'd0:    w_slot_addr = r_xa;
            2'd1:    w_slot_addr = r_xa + AW'(1);
            2'd2:    w_slot_addr = r_ya;
            default: w_slot_addr = r_ya + AW'(1);
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_addr  = w_slot_addr;
        w_wdata = 8'd0;
        if (r_state == S_CLR) begin
            w_we   = 1'b1;
            w_addr = r_clr;
        end else if (r_state == S_WR) begin
            w_we    = 1'b1;
            w_addr  = r_wa + AW'(r_widx);
            w_wdata = r_widx ? r_wdata[15:8] : r_wdata[7:0];
        end
    end

    assign o_clearing  = (r_state == S_CLR);
    assign o_take      = (r_state == S_IDLE) && i_valid;
    assign o_res_valid = (r_state == S_FIN);
    assign o_res       = r_res;
    assign w_rd_any    = (i_item.rd_x || i_item.rd_y) && !r_halt;

    // Execute stage.
    logic [15:0] e_x, e_y, e_rv1, e_nip, e_sp, e_rw_val, e_wdata;
    logic        e_skip, e_cv, e_ev, e_halt, e_rw_en, e_ok;
    logic [7:0]  e_co, e_eo;
    logic [2:0]  e_rw_idx;
    logic [1:0]  e_wn;

    always_comb begin
        e_x      = {r_byte[1], r_byte[0]};
        e_y      = {r_byte[3], r_byte[2]};
        case (r_it.rf[2:0])
            3'd0:    e_rv1 = r_gp[0];
            3'd1:    e_rv1 = r_gp[1];
            3'd2:    e_rv1 = r_gp[2];
            3'd3:    e_rv1 = r_sp;
            default: e_rv1 = r_bp;
        endcase
        e_ok     = !r_halt && (r_it.st == ST_OK);
        e_nip    = r_it.ft;
        e_skip   = 1'b0;
        e_cv     = 1'b0;
        e_co     = 8'd0;
        e_ev     = 1'b0;
        e_eo     = 8'd0;
        e_sp     = r_sp;
        e_halt   = r_halt;
        e_rw_en  = 1'b0;
        e_rw_idx = REG_R0[2:0];
        e_rw_val = 16'd0;
        e_wdata  = 16'd0;
        e_wn     = e_ok ? r_it.wn : 2'd0;
        if (e_ok) begin
            case (r_it.op)
                OP_HLT:   e_halt = 1'b1;
                OP_MOVCA: e_wdata = r_it.a;
                OP_MOVCR: begin
                    e_rw_en = 1'b1; e_rw_idx = r_it.rf[2:0]; e_rw_val = r_it.a;
                end
                OP_MOVAR: begin
                    e_rw_en = 1'b1; e_rw_idx = r_it.rf[2:0]; e_rw_val = e_x;
                end
                OP_MOVRR: begin
                    e_rw_en = 1'b1; e_rw_idx = r_it.rs[2:0]; e_rw_val = e_rv1;
                end
                OP_ADDAC: begin
                    e_rw_en = 1'b1; e_rw_val = e_x + r_it.b;
                end
                OP_ADDAA: begin
                    e_rw_en = 1'b1; e_rw_val = e_x + e_y;
                end
                OP_ADDRC: begin
                    e_rw_en = 1'b1; e_rw_val = e_rv1 + r_it.a;
                end
                OP_EQAA: begin
                    e_rw_en = 1'b1; e_rw_val = {15'd0, e_x == e_y};
                end
                OP_PEEK:  e_wdata = e_x;
                OP_IF:    e_skip = (e_x != 16'd0);
                OP_JMP:   e_nip = r_it.a;
                OP_JMPIN: e_nip = e_x;
                OP_RET: begin
                    e_nip = e_x; e_sp = r_sp - 16'd2;
                end
                OP_LEAVE: begin
                    e_sp = r_bp - 16'd2;
                    e_rw_en = 1'b1; e_rw_idx = REG_BP[2:0]; e_rw_val = e_x;
                end
                OP_CALL: begin
                    e_wdata = r_it.ft; e_sp = r_sp + 16'd2; e_nip = r_it.a;
                end
                OP_PUSHA: begin
                    e_wdata = e_x; e_sp = r_sp + 16'd2;
                end
                OP_PUSHR: begin
                    e_wdata = e_rv1; e_sp = r_sp + 16'd2;
                end
                OP_POPA: begin
                    e_wdata = e_x; e_sp = r_sp - 16'd2;
                end
                OP_POPR: begin
                    // The popped word wins when the target is the stack pointer.
                    e_sp = r_sp - 16'd2;
                    e_rw_en = 1'b1; e_rw_idx = r_it.rf[2:0]; e_rw_val = e_x;
                end
                OP_PUSHB: begin
                    e_wdata = {8'd0, e_x[7:0]}; e_sp = r_sp + 16'd1;
                end
                OP_POPB: begin
                    e_wdata = {8'd0, e_y[7:0]}; e_sp = r_sp - 16'd1;
                end
                OP_SYS: begin
                    e_wn = 2'd0;
                    if (e_x == SYS_PUTC) begin
                        e_cv = 1'b1; e_co = e_y[7:0]; e_sp = r_sp - 16'd1;
                    end else if (e_x == SYS_GETC) begin
                        e_wn = r_it.wn; e_wdata = {8'd0, r_it.sin}; e_sp = r_sp + 16'd1;
                    end else if (e_x == SYS_EXT) begin
                        e_ev = 1'b1; e_eo = e_y[7:0]; e_sp = r_sp - 16'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:  if (r_clr == {AW{1'b1}}) n_state = S_IDLE;
            S_IDLE: if (i_valid) n_state = w_rd_any ? S_RD : S_EXEC;
            S_RD:   if (!r_iss && r_cap_v) n_state = S_EXEC;
            S_EXEC: n_state = (e_wn != 2'd0) ? S_WR : S_FIN;
            S_WR:   if (2'(r_widx) + 2'd1 == r_wn) n_state = S_FIN;
            S_FIN:  if (i_res_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_cap_v) begin
            r_byte[r_cap_slot] <= w_rdata;
        end
        r_cap_slot <= r_slot;
        if (o_take) begin
            r_it       <= i_item;
            r_xa       <= AW'(f_addr(i_item.xk, i_item.a, i_item.b, r_sp, r_bp));
            r_ya       <= AW'(f_addr(i_item.yk, i_item.a, i_item.b, r_sp, r_bp));
            r_wa       <= AW'(f_addr(i_item.wk, i_item.a, i_item.b, r_sp, r_bp));
            r_slot     <= i_item.rd_x ? 2'd0 : 2'd2;
            r_slot_end <= i_item.rd_y ? 2'd3 : 2'd1;
        end else if (r_state == S_RD && r_iss && r_slot != r_slot_end) begin
            r_slot <= r_slot + 2'd1;
        end
        if (r_state == S_EXEC) begin
            r_wn    <= e_wn;
            r_wdata <= e_wdata;
            r_res   <= '{next_ip: e_nip, skip_next: e_skip, is_halted: e_halt,
                         char_valid: e_cv, char_out: e_co, ext_valid: e_ev,
                         ext_index: e_eo, status: r_halt ? ST_OK : r_it.st};
        end
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_iss   <= 1'b0;
            r_cap_v <= 1'b0;
            r_widx  <= 1'b0;
            r_gp[0] <= 16'd0;
            r_gp[1] <= 16'd0;
            r_gp[2] <= 16'd0;
            r_sp    <= 16'd0;
            r_bp    <= 16'd0;
            r_halt  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) r_clr <= r_clr + AW'(1);
            r_cap_v <= (r_state == S_RD) && r_iss;
            if (o_take) begin
                r_iss <= w_rd_any;
            end else if (r_state == S_RD && r_iss && r_slot == r_slot_end) begin
                r_iss <= 1'b0;
            end
            if (r_state == S_EXEC) begin
                r_widx <= 1'b0;
            end else if (r_state == S_WR) begin
                r_widx <= 1'b1;
            end
            if (r_state == S_EXEC) begin
                r_halt <= e_halt;
                r_sp   <= e_sp;
                if (e_rw_en) begin
                    case (e_rw_idx)
                        3'd0:    r_gp[0] <= e_rw_val;
                        3'd1:    r_gp[1] <= e_rw_val;
                        3'd2:    r_gp[2] <= e_rw_val;
                        3'd3:    r_sp    <= e_rw_val;
                        default: r_bp    <= e_rw_val;
                    endcase
                end
            end
        end
    end

endmodule

[hw/rtl/stack_vm_instruction_execute.sv]
// Top level of the stack machine instruction execute block.
// Joins the front end, the back end and the result queue. Uses svie_pkg.
//
// This block executes one pre-decoded instruction of a small 16-bit stack
// machine per input beat and returns exactly one result beat for it, in
// order. After reset the block sweeps its 64 KiB byte RAM to zero, one byte
// per cycle; full stays high during that sweep. Then the front end takes a
// beat in every cycle that its four-entry queue has room, checks register
// indexes and the opcode, and plans the RAM accesses. The back end owns the
// registers and the single-port RAM and works on one instruction at a time:
// it picks the item up, reads each operand byte in turn, waits for the
// registered read data, executes, writes each result byte in turn, and
// hands over the result. A two-entry result queue sits on the output side,
// so the back end keeps going while a result waits to be popped.
module stack_vm_instruction_execute import svie_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [4:0]  i_opcode,
    input  logic [15:0] i_operand_a,
    input  logic [15:0] i_operand_b,
    input  logic [7:0]  i_reg_first,
    input  logic [7:0]  i_reg_second,
    input  logic [15:0] i_fall_through_ip,
    input  logic [7:0]  i_stdin_byte,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_next_ip,
    output logic        o_skip_next,
    output logic        o_is_halted,
    output logic        o_char_valid,
    output logic [7:0]  o_char_out,
    output logic        o_ext_valid,
    output logic [7:0]  o_ext_index,
    output logic [1:0]  o_status
);

    logic  w_clearing, w_fq_valid, w_take, w_res_valid, w_res_ready;
    t_item w_item;
    t_res  w_res;

    svie_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .i_hold            (w_clearing),
        .i_opcode          (i_opcode),
        .i_operand_a       (i_operand_a),
        .i_operand_b       (i_operand_b),
        .i_reg_first       (i_reg_first),
        .i_reg_second      (i_reg_second),
        .i_fall_through_ip (i_fall_through_ip),
        .i_stdin_byte      (i_stdin_byte),
        .o_full            (full),
        .o_valid           (w_fq_valid),
        .o_item            (w_item),
        .i_take            (w_take)
    );

    svie_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_fq_valid),
        .i_item      (w_item),
        .o_take      (w_take),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready),
        .o_clearing  (w_clearing)
    );

    // Two-entry result queue.
    t_res       r_oq [2];
    logic       r_oq_wp, r_oq_rp;
    logic [1:0] r_oq_cnt;
    logic       w_oq_push, w_oq_pop;
    t_res       w_head;

    assign w_res_ready = (r_oq_cnt != 2'd2);
    assign w_oq_push   = w_res_valid && w_res_ready;
    assign empty       = (r_oq_cnt == 2'd0);
    assign w_oq_pop    = pop && !empty;
    assign w_head      = r_oq[r_oq_rp];

    always_ff @(posedge i_clk) begin
        if (w_oq_push) begin
            r_oq[r_oq_wp] <= w_res;
        end
        if (!i_rst_n) begin
            r_oq_wp  <= 1'b0;
            r_oq_rp  <= 1'b0;
            r_oq_cnt <= 2'd0;
        end else begin
            if (w_oq_push) r_oq_wp <= ~r_oq_wp;
            if (w_oq_pop)  r_oq_rp <= ~r_oq_rp;
            r_oq_cnt <= r_oq_cnt + 2'(w_oq_push) - 2'(w_oq_pop);
        end
    end

    assign o_next_ip    = w_head.next_ip;
    assign o_skip_next  = w_head.skip_next;
    assign o_is_halted  = w_head.is_halted;
    assign o_char_valid = w_head.char_valid;
    assign o_char_out   = w_head.char_out;
    assign o_ext_valid  = w_head.ext_valid;
    assign o_ext_index  = w_head.ext_index;
    assign o_status     = w_head.status;

    // No beat may enter while the RAM is being swept.
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> full)
        else $error("input accepted during RAM sweep");

    // The result queue never holds more than two beats.
    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oq_cnt != 2'd3)
        else $error("result queue overflow");

    // A rejected instruction never prints or calls out.
    a_reject_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ST_OK) |-> (!o_char_valid && !o_ext_valid))
        else $error("rejected instruction produced a side effect");

    // Halted results always report ok.
    a_halt_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_is_halted) |-> (o_status == ST_OK))
        else $error("halted result with error status");

endmodule
